>>> hdl/ptif_pkg.sv
// ptif_pkg: shared types and constants of the per-pixel temporal iir filter
// holds the register map, the coefficient set and the state machine encodings
// no dependencies
package ptif_pkg;

	localparam int PIXELS_DEF    = 65536;
	localparam int MAX_ORDER_DEF = 6;
	localparam int NUM_COEF      = 6;
	localparam int IDX_W         = 16;
	localparam int SMP_W         = 16;
	localparam int VAL_W         = 24;
	localparam int ORD_W         = 3;
	localparam int CFG_IDX_W     = 3;
	localparam int COEF_IDX_W    = 3;
	localparam int QUEUE_DEPTH   = 2;
	localparam int ACC_W         = 52;
	localparam int PROD_W        = 48;
	localparam int FRAC_SHIFT    = 18;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORDER = 3'd0,
		REG_GAIN  = 3'd1,
		REG_A1    = 3'd2,
		REG_A2    = 3'd3,
		REG_A3    = 3'd4,
		REG_A4    = 3'd5,
		REG_A5    = 3'd6,
		REG_A6    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [ORD_W-1:0]               order;
		logic signed [VAL_W-1:0]        gain;
		logic [NUM_COEF-1:0][VAL_W-1:0] coef;
	} cfg_t;

	typedef struct packed {
		logic clearing;
		logic busy;
	} bk_status_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_DIV,
		FR_REM,
		FR_PUSH
	} fr_state_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_GAIN,
		BK_MAC,
		BK_DRAIN,
		BK_ROUND
	} bk_state_t;

endpackage

>>> hdl/per_pixel_temporal_iir_filter.sv
// per_pixel_temporal_iir_filter: one beat in, one beat out; a beat passes through
// the front, the queue and the back. throughput is set by the serial tap loop in
// the back and by output back-pressure; the front takes the next beat while the
// back works and overlaps with it through the queue.
// after arst_n the history memory is swept to zero, row by row; beats are
// queued but not processed until the sweep ends. config registers reset at once.
module per_pixel_temporal_iir_filter import ptif_pkg::*; #(
	parameter int PIXELS    = PIXELS_DEF,
	parameter int MAX_ORDER = MAX_ORDER_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [31:0]          s_axis_tdata,  // pixel_index, sample
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [39:0]          m_axis_tdata,  // out_pixel_index, filtered
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]     cfg_data
);

	localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
	localparam int QW = AW + SMP_W + IDX_W;

	cfg_t             cfg_q;
	logic             push, q_full, q_pop, q_valid;
	logic [IDX_W-1:0] f_pidx, o_pidx;
	logic [SMP_W-1:0] f_sample;
	logic [AW-1:0]    f_slot;
	logic [QW-1:0]    q_wdata, q_rdata;
	logic [VAL_W-1:0] o_filt;
	bk_status_t       bk_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.order <= ORD_W'(1);
			cfg_q.gain  <= '0;
			cfg_q.coef  <= '0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ORDER: cfg_q.order <= cfg_data[ORD_W-1:0];
				REG_GAIN:  cfg_q.gain  <= cfg_data;
				REG_A1, REG_A2, REG_A3, REG_A4, REG_A5, REG_A6:
					cfg_q.coef[COEF_IDX_W'(cfg_index - REG_A1)] <= cfg_data;
				default: ;
			endcase
		end
	end

	ptif_front #(.PIXELS(PIXELS), .AW(AW)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_pidx     (s_axis_tdata[15:0]),
		.in_sample   (s_axis_tdata[31:16]),
		.push        (push),
		.q_full      (q_full),
		.item_pidx   (f_pidx),
		.item_sample (f_sample),
		.item_slot   (f_slot)
	);

	assign q_wdata = {f_slot, f_sample, f_pidx};

	ptif_queue #(.W(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.rdata     (q_rdata)
	);

	ptif_back #(.PIXELS(PIXELS), .MAX_ORDER(MAX_ORDER), .AW(AW)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_pidx       (q_rdata[IDX_W-1:0]),
		.q_sample     (q_rdata[IDX_W +: SMP_W]),
		.q_slot       (q_rdata[IDX_W+SMP_W +: AW]),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_pidx     (o_pidx),
		.out_filtered (o_filt),
		.status       (bk_stat)
	);

	assign m_axis_tdata = {o_filt, o_pidx};

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full) else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("queue read while empty");
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.clearing |-> !q_pop && !bk_stat.busy)
		else $error("item taken during history clear");
	a_out_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(bk_stat.busy))
		else $error("output beat without work behind it");

endmodule

>>> hdl/ptif_front.sv
// ptif_front: accepts input beats and reduces the pixel index to a history row
// reciprocal multiply in FR_DIV, then one compare and subtract in FR_REM; depends on ptif_pkg
module ptif_front import ptif_pkg::*; #(
	parameter int PIXELS = PIXELS_DEF,
	parameter int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [IDX_W-1:0]        in_pidx,
	input  logic signed [SMP_W-1:0] in_sample,
	output logic                    push,
	input  logic                    q_full,
	output logic [IDX_W-1:0]        item_pidx,
	output logic [SMP_W-1:0]        item_sample,
	output logic [AW-1:0]           item_slot
);

	// quotient estimate from floor(2^32 / PIXELS) is at most one low for a
	// 16 bit index, so a single correction step finishes the remainder
	localparam int RW = 33;
	localparam int QW = IDX_W + RW;
	localparam int PW = $clog2(PIXELS + 1);
	localparam int MW = IDX_W + PW;
	localparam logic [RW-1:0] RECIP = RW'((64'd1 << 32) / 64'(PIXELS));

	fr_state_t          state_q, state_d;
	logic [IDX_W-1:0]   pidx_q;
	logic [SMP_W-1:0]   sample_q;
	logic [IDX_W-1:0]   quo_q;
	logic [AW-1:0]      rem_q;
	logic [QW-1:0]      qprod;
	logic [MW-1:0]      rem_raw;
	logic [MW-1:0]      rem_fix;
	logic               take;

	assign qprod    = QW'(pidx_q) * QW'(RECIP);
	assign rem_raw  = MW'(pidx_q) - MW'(quo_q) * MW'(PIXELS);
	assign rem_fix  = (rem_raw >= MW'(PIXELS)) ? rem_raw - MW'(PIXELS) : rem_raw;
	assign take     = in_valid && in_ready;
	assign in_ready = (state_q == FR_IDLE);

	always_comb begin
		state_d = state_q;
		push    = 1'b0;
		unique case (state_q)
			FR_IDLE: if (in_valid) state_d = FR_DIV;
			FR_DIV:  state_d = FR_REM;
			FR_REM:  state_d = FR_PUSH;
			FR_PUSH: begin
				push = !q_full;
				if (!q_full) state_d = FR_IDLE;
			end
			default: state_d = FR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pidx_q   <= in_pidx;
			sample_q <= in_sample;
		end
		if (state_q == FR_DIV) quo_q <= IDX_W'(qprod >> 32);
		if (state_q == FR_REM) rem_q <= AW'(rem_fix);
	end

	assign item_pidx   = pidx_q;
	assign item_sample = sample_q;
	assign item_slot   = rem_q;

endmodule

>>> hdl/ptif_queue.sv
// ptif_queue: short fifo between the front and the back
// depends on ptif_pkg for its depth
module ptif_queue import ptif_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output logic [W-1:0] rdata
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]  slots_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= wdata;
	end

endmodule

>>> hdl/ptif_back.sv
// ptif_back: history memory, multiply-accumulate over the taps, rounding and
// the output register; depends on ptif_pkg
module ptif_back import ptif_pkg::*; #(
	parameter int PIXELS    = PIXELS_DEF,
	parameter int MAX_ORDER = MAX_ORDER_DEF,
	parameter int AW        = (PIXELS > 1) ? $clog2(PIXELS) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    q_valid,
	output logic                    q_pop,
	input  logic [IDX_W-1:0]        q_pidx,
	input  logic signed [SMP_W-1:0] q_sample,
	input  logic [AW-1:0]           q_slot,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [IDX_W-1:0]        out_pidx,
	output logic [VAL_W-1:0]        out_filtered,
	output bk_status_t              status
);

	localparam int ROW_W = MAX_ORDER * VAL_W;
	localparam int TW    = $clog2(MAX_ORDER + 1);
	localparam int YW    = ACC_W - FRAC_SHIFT;

	logic [ROW_W-1:0]         mem [PIXELS];
	logic [ROW_W-1:0]         rd_data_q;
	logic [ROW_W-1:0]         wr_row;
	logic [AW-1:0]            wr_addr;
	logic                     we;

	bk_state_t                state_q, state_d;
	logic [AW-1:0]            clr_addr_q;
	logic [TW-1:0]            tap_q, taps;
	logic [IDX_W-1:0]         pidx_q;
	logic signed [SMP_W-1:0]  sample_q;
	logic [AW-1:0]            slot_q;
	logic signed [VAL_W-1:0]  hist_q [MAX_ORDER];
	logic signed [PROD_W-1:0] prod_q;
	logic                     prod_add_q;
	logic signed [ACC_W-1:0]  acc_q, acc_next;
	logic signed [39:0]       gprod;
	logic signed [VAL_W-1:0]  coef_sel, hist_sel;
	logic signed [YW-1:0]     y_wide;
	logic signed [VAL_W-1:0]  y_sat;
	logic                     out_valid_q;
	logic [IDX_W-1:0]         out_pidx_q;
	logic [VAL_W-1:0]         out_filt_q;
	logic                     out_free;

	assign taps     = (cfg.order > ORD_W'(MAX_ORDER)) ? TW'(MAX_ORDER) : TW'(cfg.order);
	assign gprod    = cfg.gain * sample_q;
	assign coef_sel = cfg.coef[COEF_IDX_W'(tap_q)];
	assign hist_sel = hist_q[tap_q];
	assign acc_next = prod_add_q ? acc_q + ACC_W'(prod_q) : acc_q - ACC_W'(prod_q);
	assign y_wide   = YW'(acc_q >>> FRAC_SHIFT);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		if (y_wide > YW'(8388607)) y_sat = 24'sh7FFFFF;
		else if (y_wide < -YW'(8388608)) y_sat = 24'sh800000;
		else y_sat = VAL_W'(y_wide);
	end

	// newest output goes to the lowest entry, the rest move up one
	always_comb begin
		wr_row = '0;
		if (state_q != BK_CLEAR) begin
			wr_row[VAL_W-1:0] = y_sat;
			for (int i = 1; i < MAX_ORDER; i++) wr_row[i*VAL_W +: VAL_W] = hist_q[i-1];
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		we      = 1'b0;
		wr_addr = slot_q;
		unique case (state_q)
			BK_CLEAR: begin
				we      = 1'b1;
				wr_addr = clr_addr_q;
				if (clr_addr_q == AW'(PIXELS - 1)) state_d = BK_IDLE;
			end
			BK_IDLE: begin
				q_pop = q_valid;
				if (q_valid) state_d = BK_GAIN;
			end
			BK_GAIN:  state_d = (taps == '0) ? BK_DRAIN : BK_MAC;
			BK_MAC:   if (tap_q + 1'b1 == taps) state_d = BK_DRAIN;
			BK_DRAIN: state_d = BK_ROUND;
			BK_ROUND: begin
				we = out_free;
				if (out_free) state_d = BK_IDLE;
			end
			default:  state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) rd_data_q <= mem[q_slot];
	end

	always_ff @(posedge clk) begin
		if (we) mem[wr_addr] <= wr_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) clr_addr_q <= clr_addr_q + 1'b1;
			if (state_q == BK_ROUND && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			pidx_q   <= q_pidx;
			sample_q <= q_sample;
			slot_q   <= q_slot;
		end
		unique case (state_q)
			BK_GAIN: begin
				for (int i = 0; i < MAX_ORDER; i++) hist_q[i] <= rd_data_q[i*VAL_W +: VAL_W];
				prod_q     <= {gprod, 8'b0};
				prod_add_q <= 1'b1;
				acc_q      <= ACC_W'(131072);
				tap_q      <= '0;
			end
			BK_MAC: begin
				acc_q      <= acc_next;
				prod_q     <= coef_sel * hist_sel;
				prod_add_q <= 1'b0;
				tap_q      <= tap_q + 1'b1;
			end
			BK_DRAIN: acc_q <= acc_next;
			BK_ROUND: if (out_free) begin
				out_pidx_q <= pidx_q;
				out_filt_q <= y_sat;
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign out_pidx        = out_pidx_q;
	assign out_filtered    = out_filt_q;
	assign status.clearing = (state_q == BK_CLEAR);
	assign status.busy     = (state_q != BK_IDLE) && (state_q != BK_CLEAR);

endmodule

>>> tb/per_pixel_temporal_iir_filter_chk.sv
// checker for the per-pixel temporal iir filter: watches the config, input and
// output channels, keeps its own history store and compares every output beat
// depends on ptif_pkg
module per_pixel_temporal_iir_filter_chk import ptif_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [31:0]          s_axis_tdata,
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [39:0]          m_axis_tdata,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]     cfg_data,
	output int                   errors,
	output int                   pending
);

	typedef struct {
		logic [IDX_W-1:0]        pix;
		logic signed [VAL_W-1:0] val;
	} pix_out_t;

	logic [ORD_W-1:0]        order_r;
	logic signed [VAL_W-1:0] gain_r;
	logic signed [VAL_W-1:0] coef_r [NUM_COEF];
	logic signed [VAL_W-1:0] hist [PIXELS_DEF][MAX_ORDER_DEF];
	pix_out_t                filtered_q[$];

	function automatic void store_exp(pix_out_t item);
		filtered_q.insert(filtered_q.size(), item);
	endfunction

	function automatic logic signed [VAL_W-1:0] filter_pixel(logic [IDX_W-1:0] pix,
			logic signed [SMP_W-1:0] smp);
		longint acc;
		longint y;
		int taps;
		taps = (order_r > MAX_ORDER_DEF) ? MAX_ORDER_DEF : order_r;
		acc = longint'(gain_r) * longint'(smp) * 256;
		for (int k = 0; k < taps; k++)
			acc -= longint'(coef_r[k]) * longint'(hist[pix][k]);
		y = (acc + 131072) >>> FRAC_SHIFT;
		if (y > 8388607)
			y = 8388607;
		if (y < -8388608)
			y = -8388608;
		for (int i = MAX_ORDER_DEF - 1; i > 0; i--)
			hist[pix][i] = hist[pix][i-1];
		hist[pix][0] = VAL_W'(y);
		return VAL_W'(y);
	endfunction

	initial begin
		errors = 0;
		pending = 0;
		order_r = 1;
		gain_r = 0;
		for (int k = 0; k < NUM_COEF; k++)
			coef_r[k] = 0;
		for (int p = 0; p < PIXELS_DEF; p++)
			for (int k = 0; k < MAX_ORDER_DEF; k++)
				hist[p][k] = 0;
	end

	always @(posedge clk) begin
		pix_out_t e;
		pix_out_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_ORDER: order_r <= cfg_data[ORD_W-1:0];
					REG_GAIN:  gain_r <= cfg_data;
					default:   coef_r[cfg_index - REG_A1] <= cfg_data;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				e.pix = s_axis_tdata[15:0];
				e.val = filter_pixel(s_axis_tdata[15:0], s_axis_tdata[31:16]);
				store_exp(e);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.pix = m_axis_tdata[15:0];
				got.val = m_axis_tdata[39:16];
				if (filtered_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected beat: pix %0d val %0d", got.pix, got.val);
				end else begin
					e = filtered_q.pop_front();
					if (e.pix !== got.pix || e.val !== got.val) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected pix %0d val %0d, got pix %0d val %0d",
								e.pix, e.val, got.pix, got.val);
					end
				end
			end
			pending = filtered_q.size();
		end
	end

endmodule

>>> tb/per_pixel_temporal_iir_filter_tb.sv
// testbench top for the per-pixel temporal iir filter: drives config, pixel
// beats and output back-pressure; verdict from the checker's error count
// depends on ptif_pkg, per_pixel_temporal_iir_filter, per_pixel_temporal_iir_filter_chk
module per_pixel_temporal_iir_filter_tb;
	import ptif_pkg::*;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 s_axis_tvalid = 0;
	logic                 s_axis_tready;
	logic [31:0]          s_axis_tdata = 0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 0;
	logic [39:0]          m_axis_tdata;
	logic                 cfg_valid = 0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_ORDER;
	logic [VAL_W-1:0]     cfg_data = 0;
	int                   errors;
	int                   pending;
	bit                   rx_stall_on = 1;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	per_pixel_temporal_iir_filter dut (.*);
	per_pixel_temporal_iir_filter_chk chk (.*);

	// output back-pressure, random per beat while rx_stall_on is set
	initial begin
		int w;
		forever begin
			@(posedge clk);
			m_axis_tready <= 1;
			while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk);
			w = rx_stall_on ? $urandom_range(0, 8) : 0;
			if (w > 0) begin
				m_axis_tready <= 0;
				repeat (w - 1) @(posedge clk);
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [VAL_W-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// valid stays high after a beat, so back-to-back beats leave no gap in valid
	task automatic send_pixel(logic [15:0] pix, logic [15:0] smp, bit gaps);
		int w;
		w = gaps ? $urandom_range(0, 8) : 0;
		if (w > 0) begin
			s_axis_tvalid <= 0;
			repeat (w) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {smp, pix};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// random coefficients kept small so the recursion mostly stays in range,
	// with occasional full-scale values to hit saturation
	function automatic logic [VAL_W-1:0] rand_coef();
		if ($urandom_range(0, 7) == 0)
			return VAL_W'($urandom);
		return VAL_W'($signed($urandom_range(0, 131072)) - 65536);
	endfunction

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: order 1, gain 256, extremes of the fields
		write_reg(REG_GAIN, 24'h040000);
		write_reg(REG_A1, 24'h3FFFFF & 24'hFE0000);
		send_pixel(16'h0000, 16'h7FFF, 1'b0);
		send_pixel(16'hFFFF, 16'h8000, 1'b0);
		send_pixel(16'h0000, 16'h0000, 1'b0);
		send_pixel(16'h5555, 16'hFFFF, 1'b0);
		send_pixel(16'hAAAA, 16'h0001, 1'b0);
		drain();
		// order zero: gain term alone; extreme gain gives saturation
		write_reg(REG_ORDER, 24'd0);
		write_reg(REG_GAIN, 24'h7FFFFF);
		send_pixel(16'h0001, 16'h7FFF, 1'b0);
		send_pixel(16'h0001, 16'h8000, 1'b0);
		drain();
		write_reg(REG_GAIN, 24'h800000);
		send_pixel(16'h0001, 16'h7FFF, 1'b0);
		send_pixel(16'h0001, 16'h8000, 1'b0);
		drain();
		// orders 6 and 7 (7 is above range), with extreme values in A2 and A3
		write_reg(REG_GAIN, 24'h010000);
		write_reg(REG_A2, 24'h7FFFFF);
		write_reg(REG_A3, 24'h800000);
		write_reg(REG_A4, 24'h001000);
		write_reg(REG_A5, 24'hFFF000);
		write_reg(REG_A6, 24'h000800);
		write_reg(REG_ORDER, 24'd6);
		for (int i = 0; i < 4; i++)
			send_pixel(16'h0001, 16'(i * 9000), 1'b0);
		drain();
		write_reg(REG_ORDER, 24'd7);
		for (int i = 0; i < 4; i++)
			send_pixel(16'h0001, 16'(-i * 7000), 1'b0);
		drain();

		// random phases, mostly over a small pixel set so histories build up
		for (int ph = 0; ph < 10; ph++) begin
			write_reg(REG_ORDER, VAL_W'($urandom_range(0, 7)));
			write_reg(REG_GAIN, rand_coef());
			for (int k = 0; k < NUM_COEF; k++)
				write_reg(reg_idx_t'(REG_A1 + k), rand_coef());
			rx_stall_on = (ph % 3 != 2);
			for (int i = 0; i < 122; i++) begin
				logic [15:0] pix;
				pix = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
				send_pixel(pix, 16'($urandom), (ph % 4 != 3));
			end
			drain();
		end

		if (errors == 0)
			$display("per_pixel_temporal_iir_filter_tb: clean");
		else
			$display("per_pixel_temporal_iir_filter_tb: errors");
		$finish;
	end

	initial begin
		#8000000;
		$display("per_pixel_temporal_iir_filter_tb: errors");
		$finish;
	end

endmodule

>>> filelist.f
hdl/ptif_pkg.sv
hdl/ptif_front.sv
hdl/ptif_queue.sv
hdl/ptif_back.sv
hdl/per_pixel_temporal_iir_filter.sv
tb/per_pixel_temporal_iir_filter_chk.sv
tb/per_pixel_temporal_iir_filter_tb.sv
